[rtl/ple_pkg.sv]
package ple_pkg;

   localparam logic [3:0] REQ_INS_FIRST = 4'd0;
   localparam logic [3:0] REQ_INS_LAST  = 4'd1;
   localparam logic [3:0] REQ_INS_AT    = 4'd2;
   localparam logic [3:0] REQ_DEL_FIRST = 4'd3;
   localparam logic [3:0] REQ_DEL_LAST  = 4'd4;
   localparam logic [3:0] REQ_DEL_AT    = 4'd5;
   localparam logic [3:0] REQ_UPD_FIRST = 4'd6;
   localparam logic [3:0] REQ_UPD_LAST  = 4'd7;
   localparam logic [3:0] REQ_UPD_AT    = 4'd8;
   localparam logic [3:0] REQ_ASC       = 4'd9;
   localparam logic [3:0] REQ_DESC      = 4'd10;
   localparam logic [3:0] REQ_SEARCH    = 4'd11;
   localparam logic [3:0] REQ_DISPLAY   = 4'd12;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_RANGE    = 3'd2,
      ST_FULL     = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      VS_ZERO,
      VS_REQ,
      VS_A,
      VS_RD
   } vsel_type;

   typedef enum logic [1:0] {
      PS_ZERO,
      PS_IDX,
      PS_MPOS,
      PS_I
   } psel_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_INS_START,
      OP_INS_RD,
      OP_INS_WR,
      OP_INS_FIN,
      OP_DEL_START,
      OP_DEL_SAVE,
      OP_DEL_RD,
      OP_DEL_WR,
      OP_DEL_FIN,
      OP_UPD,
      OP_SORT_INIT,
      OP_SORT_RA,
      OP_SORT_LA,
      OP_SORT_RB,
      OP_SORT_CMP,
      OP_SORT_WI,
      OP_SCAN_INIT,
      OP_SCAN_RD,
      OP_SRCH_CHK,
      OP_DISP_NEXT
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_INS_CHK,
      S_INS_WR,
      S_DEL_SAVE,
      S_DEL_CHK,
      S_DEL_WR,
      S_EMIT_IDX,
      S_SORT_OUT,
      S_SORT_LA,
      S_SORT_IN,
      S_SORT_CMP,
      S_EMIT_OK,
      S_SRCH_RD,
      S_SRCH_CHK,
      S_SRCH_END,
      S_DISP_RD,
      S_DISP_EMIT
   } state_type;

   typedef struct packed {
      op_type     op;
      logic       emit;
      status_type st;
      vsel_type   vsel;
      psel_type   psel;
      logic       last;
   } cmd_type;

   typedef struct packed {
      logic [3:0] req_type;
      logic       full;
      logic       empty;
      logic       ins_pos_ok;
      logic       pos_ok;
      logic       ins_more;
      logic       del_more;
      logic       i_lt;
      logic       j_lt;
      logic       match;
      logic       pend;
      logic       disp_last;
      logic       out_free;
   } flags_type;

endpackage

[rtl/ple_dp.sv]
module ple_dp #(
   parameter int CAPACITY = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  ple_pkg::cmd_type    cmd,
   output ple_pkg::flags_type  flags,
   input  logic [3:0]          req_type,
   input  logic [4:0]          req_position,
   input  logic signed [31:0]  req_element_value,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_status,
   output logic signed [31:0]  rsp_out_value,
   output logic [4:0]          rsp_out_position,
   output logic [4:0]          rsp_element_count,
   output logic                rsp_last_result
);

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = $clog2(CAPACITY);
   localparam int EW = ((CW > 5) ? CW : 5) + 1;

   logic [31:0]   mem [CAPACITY];
   logic          we;
   logic [CW-1:0] wa;
   logic [31:0]   wd;
   logic          re;
   logic [CW-1:0] ra;

   logic [3:0]    type_ff;
   logic [4:0]    pos_ff;
   logic [31:0]   val_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] mpos_ff, mpos_in;
   logic          pend_ff, pend_in;
   logic [31:0]   a_ff, a_in;
   logic [31:0]   rd_ff;

   logic          rsp_valid_ff;
   logic [2:0]    rsp_status_ff;
   logic [31:0]   rsp_value_ff;
   logic [4:0]    rsp_pos_ff;
   logic [4:0]    rsp_count_ff;
   logic          rsp_last_ff;

   logic [EW-1:0] pos_e, cnt_e, i_e, idx_e, mpos_e, cnt_x;
   logic [EW-1:0] tgt_e;
   logic [CW-1:0] tgt;
   logic          swap;
   logic [31:0]   emit_val;
   logic [EW-1:0] emit_pos;

   assign pos_e  = EW'(pos_ff);
   assign cnt_e  = EW'(count_ff);
   assign i_e    = EW'(i_ff);
   assign idx_e  = EW'(idx_ff);
   assign mpos_e = EW'(mpos_ff);
   assign cnt_x  = EW'(count_ff);

   always_comb begin
      case (type_ff)
         ple_pkg::REQ_INS_FIRST, ple_pkg::REQ_DEL_FIRST, ple_pkg::REQ_UPD_FIRST:
            tgt_e = '0;
         ple_pkg::REQ_INS_LAST: tgt_e = cnt_e;
         ple_pkg::REQ_DEL_LAST, ple_pkg::REQ_UPD_LAST: tgt_e = cnt_e - EW'(1);
         default: tgt_e = pos_e - EW'(1);
      endcase
   end
   assign tgt = tgt_e[CW-1:0];

   assign swap = (type_ff == ple_pkg::REQ_DESC) ? ($signed(a_ff) < $signed(rd_ff))
                                                : ($signed(a_ff) > $signed(rd_ff));

   always_comb begin
      flags.req_type   = type_ff;
      flags.full       = (count_ff == CW'(CAPACITY));
      flags.empty      = (count_ff == '0);
      flags.ins_pos_ok = (pos_e != '0) && (pos_e <= cnt_e + EW'(1));
      flags.pos_ok     = (pos_e != '0) && (pos_e <= cnt_e);
      flags.ins_more   = (i_ff > idx_ff);
      flags.del_more   = (i_e + EW'(1) < cnt_e);
      flags.i_lt       = (i_ff < count_ff);
      flags.j_lt       = (j_ff < count_ff);
      flags.match      = (rd_ff == val_ff);
      flags.pend       = pend_ff;
      flags.disp_last  = (i_e + EW'(1) == cnt_e);
      flags.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      count_in = count_ff;
      idx_in   = idx_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      mpos_in  = mpos_ff;
      pend_in  = pend_ff;
      a_in     = a_ff;
      we       = 1'b0;
      wa       = i_ff;
      wd       = rd_ff;
      re       = 1'b0;
      ra       = i_ff;
      case (cmd.op)
         ple_pkg::OP_INS_START: begin
            idx_in = tgt;
            i_in   = count_ff;
            a_in   = val_ff;
         end
         ple_pkg::OP_INS_RD: begin
            re = 1'b1;
            ra = i_ff - CW'(1);
         end
         ple_pkg::OP_INS_WR: begin
            we   = 1'b1;
            i_in = i_ff - CW'(1);
         end
         ple_pkg::OP_INS_FIN: begin
            we       = 1'b1;
            wa       = idx_ff;
            wd       = val_ff;
            count_in = count_ff + CW'(1);
         end
         ple_pkg::OP_DEL_START: begin
            idx_in = tgt;
            i_in   = tgt;
            re     = 1'b1;
            ra     = tgt;
         end
         ple_pkg::OP_DEL_SAVE: a_in = rd_ff;
         ple_pkg::OP_DEL_RD: begin
            re = 1'b1;
            ra = i_ff + CW'(1);
         end
         ple_pkg::OP_DEL_WR: begin
            we   = 1'b1;
            i_in = i_ff + CW'(1);
         end
         ple_pkg::OP_DEL_FIN: count_in = count_ff - CW'(1);
         ple_pkg::OP_UPD: begin
            idx_in = tgt;
            a_in   = val_ff;
            we     = 1'b1;
            wa     = tgt;
            wd     = val_ff;
         end
         ple_pkg::OP_SORT_INIT: i_in = '0;
         ple_pkg::OP_SORT_RA: begin
            re   = 1'b1;
            j_in = i_ff + CW'(1);
         end
         ple_pkg::OP_SORT_LA: a_in = rd_ff;
         ple_pkg::OP_SORT_RB: begin
            re = 1'b1;
            ra = j_ff;
         end
         ple_pkg::OP_SORT_CMP: begin
            if (swap) begin
               we   = 1'b1;
               wa   = j_ff;
               wd   = a_ff;
               a_in = rd_ff;
            end
            j_in = j_ff + CW'(1);
         end
         ple_pkg::OP_SORT_WI: begin
            we   = 1'b1;
            wd   = a_ff;
            i_in = i_ff + CW'(1);
         end
         ple_pkg::OP_SCAN_INIT: begin
            i_in    = '0;
            pend_in = 1'b0;
         end
         ple_pkg::OP_SCAN_RD: re = 1'b1;
         ple_pkg::OP_SRCH_CHK: begin
            if (rd_ff == val_ff) begin
               mpos_in = i_ff;
               pend_in = 1'b1;
            end
            i_in = i_ff + CW'(1);
         end
         ple_pkg::OP_DISP_NEXT: i_in = i_ff + CW'(1);
         default: ;
      endcase
   end

   always_comb begin
      case (cmd.vsel)
         ple_pkg::VS_REQ: emit_val = val_ff;
         ple_pkg::VS_A:   emit_val = a_ff;
         ple_pkg::VS_RD:  emit_val = rd_ff;
         default:         emit_val = '0;
      endcase
      case (cmd.psel)
         ple_pkg::PS_IDX:  emit_pos = idx_e + EW'(1);
         ple_pkg::PS_MPOS: emit_pos = mpos_e + EW'(1);
         ple_pkg::PS_I:    emit_pos = i_e + EW'(1);
         default:          emit_pos = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa[IW-1:0]] <= wd;
      end
      if (re) begin
         rd_ff <= mem[ra[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == ple_pkg::OP_LOAD) begin
         type_ff <= req_type;
         pos_ff  <= req_position;
         val_ff  <= req_element_value;
      end
      idx_ff  <= idx_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      mpos_ff <= mpos_in;
      a_ff    <= a_in;
      if (cmd.emit) begin
         rsp_status_ff <= cmd.st;
         rsp_value_ff  <= emit_val;
         rsp_pos_ff    <= emit_pos[4:0];
         rsp_count_ff  <= cnt_x[4:0];
         rsp_last_ff   <= cmd.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= pend_in;
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_value     = rsp_value_ff;
   assign rsp_out_position  = rsp_pos_ff;
   assign rsp_element_count = rsp_count_ff;
   assign rsp_last_result   = rsp_last_ff;

endmodule

[rtl/ple_ctrl.sv]
module ple_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  ple_pkg::flags_type  flags,
   output ple_pkg::cmd_type    cmd
);

   ple_pkg::state_type state_ff, state_in;
   logic is_ins, is_del, is_upd, is_at, is_sort;

   always_comb begin
      is_ins  = (flags.req_type == ple_pkg::REQ_INS_FIRST)
             || (flags.req_type == ple_pkg::REQ_INS_LAST)
             || (flags.req_type == ple_pkg::REQ_INS_AT);
      is_del  = (flags.req_type == ple_pkg::REQ_DEL_FIRST)
             || (flags.req_type == ple_pkg::REQ_DEL_LAST)
             || (flags.req_type == ple_pkg::REQ_DEL_AT);
      is_upd  = (flags.req_type == ple_pkg::REQ_UPD_FIRST)
             || (flags.req_type == ple_pkg::REQ_UPD_LAST)
             || (flags.req_type == ple_pkg::REQ_UPD_AT);
      is_at   = (flags.req_type == ple_pkg::REQ_DEL_AT)
             || (flags.req_type == ple_pkg::REQ_UPD_AT);
      is_sort = (flags.req_type == ple_pkg::REQ_ASC)
             || (flags.req_type == ple_pkg::REQ_DESC);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ple_pkg::S_IDLE: if (req_valid) state_in = ple_pkg::S_DECODE;
         ple_pkg::S_DECODE: begin
            if (is_ins) begin
               if (flags.full || (flags.req_type == ple_pkg::REQ_INS_AT && !flags.ins_pos_ok))
               begin
                  if (flags.out_free) state_in = ple_pkg::S_IDLE;
               end else begin
                  state_in = ple_pkg::S_INS_CHK;
               end
            end else if (is_del || is_upd) begin
               if (flags.empty || (is_at && !flags.pos_ok)) begin
                  if (flags.out_free) state_in = ple_pkg::S_IDLE;
               end else if (is_del) begin
                  state_in = ple_pkg::S_DEL_SAVE;
               end else begin
                  state_in = ple_pkg::S_EMIT_IDX;
               end
            end else if (is_sort) begin
               if (flags.empty) begin
                  if (flags.out_free) state_in = ple_pkg::S_IDLE;
               end else begin
                  state_in = ple_pkg::S_SORT_OUT;
               end
            end else if (flags.req_type == ple_pkg::REQ_SEARCH) begin
               state_in = ple_pkg::S_SRCH_RD;
            end else if (flags.req_type == ple_pkg::REQ_DISPLAY) begin
               if (flags.empty) begin
                  if (flags.out_free) state_in = ple_pkg::S_IDLE;
               end else begin
                  state_in = ple_pkg::S_DISP_RD;
               end
            end else if (flags.out_free) begin
               state_in = ple_pkg::S_IDLE;
            end
         end
         ple_pkg::S_INS_CHK:
            state_in = flags.ins_more ? ple_pkg::S_INS_WR : ple_pkg::S_EMIT_IDX;
         ple_pkg::S_INS_WR:   state_in = ple_pkg::S_INS_CHK;
         ple_pkg::S_DEL_SAVE: state_in = ple_pkg::S_DEL_CHK;
         ple_pkg::S_DEL_CHK:
            state_in = flags.del_more ? ple_pkg::S_DEL_WR : ple_pkg::S_EMIT_IDX;
         ple_pkg::S_DEL_WR:   state_in = ple_pkg::S_DEL_CHK;
         ple_pkg::S_EMIT_IDX: if (flags.out_free) state_in = ple_pkg::S_IDLE;
         ple_pkg::S_SORT_OUT:
            state_in = flags.i_lt ? ple_pkg::S_SORT_LA : ple_pkg::S_EMIT_OK;
         ple_pkg::S_SORT_LA:  state_in = ple_pkg::S_SORT_IN;
         ple_pkg::S_SORT_IN:
            state_in = flags.j_lt ? ple_pkg::S_SORT_CMP : ple_pkg::S_SORT_OUT;
         ple_pkg::S_SORT_CMP: state_in = ple_pkg::S_SORT_IN;
         ple_pkg::S_EMIT_OK:  if (flags.out_free) state_in = ple_pkg::S_IDLE;
         ple_pkg::S_SRCH_RD:
            state_in = flags.i_lt ? ple_pkg::S_SRCH_CHK : ple_pkg::S_SRCH_END;
         ple_pkg::S_SRCH_CHK:
            if (!(flags.match && flags.pend && !flags.out_free)) state_in = ple_pkg::S_SRCH_RD;
         ple_pkg::S_SRCH_END: if (flags.out_free) state_in = ple_pkg::S_IDLE;
         ple_pkg::S_DISP_RD:  state_in = ple_pkg::S_DISP_EMIT;
         ple_pkg::S_DISP_EMIT:
            if (flags.out_free) state_in = flags.disp_last ? ple_pkg::S_IDLE : ple_pkg::S_DISP_RD;
         default: state_in = ple_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op    = ple_pkg::OP_NONE;
      cmd.emit  = 1'b0;
      cmd.st    = ple_pkg::ST_OK;
      cmd.vsel  = ple_pkg::VS_ZERO;
      cmd.psel  = ple_pkg::PS_ZERO;
      cmd.last  = 1'b1;
      req_stall = (state_ff != ple_pkg::S_IDLE);
      case (state_ff)
         ple_pkg::S_IDLE: if (req_valid) cmd.op = ple_pkg::OP_LOAD;
         ple_pkg::S_DECODE: begin
            if (is_ins) begin
               if (flags.full) begin
                  cmd.emit = flags.out_free;
                  cmd.st   = ple_pkg::ST_FULL;
               end else if (flags.req_type == ple_pkg::REQ_INS_AT && !flags.ins_pos_ok) begin
                  cmd.emit = flags.out_free;
                  cmd.st   = ple_pkg::ST_RANGE;
               end else begin
                  cmd.op = ple_pkg::OP_INS_START;
               end
            end else if (is_del || is_upd) begin
               if (flags.empty) begin
                  cmd.emit = flags.out_free;
                  cmd.st   = ple_pkg::ST_EMPTY;
               end else if (is_at && !flags.pos_ok) begin
                  cmd.emit = flags.out_free;
                  cmd.st   = ple_pkg::ST_RANGE;
               end else if (is_del) begin
                  cmd.op = ple_pkg::OP_DEL_START;
               end else begin
                  cmd.op = ple_pkg::OP_UPD;
               end
            end else if (is_sort) begin
               if (flags.empty) begin
                  cmd.emit = flags.out_free;
                  cmd.st   = ple_pkg::ST_EMPTY;
               end else begin
                  cmd.op = ple_pkg::OP_SORT_INIT;
               end
            end else if (flags.req_type == ple_pkg::REQ_SEARCH) begin
               cmd.op = ple_pkg::OP_SCAN_INIT;
            end else if (flags.req_type == ple_pkg::REQ_DISPLAY) begin
               if (flags.empty) begin
                  cmd.emit = flags.out_free;
                  cmd.st   = ple_pkg::ST_EMPTY;
               end else begin
                  cmd.op = ple_pkg::OP_SCAN_INIT;
               end
            end else begin
               cmd.emit = flags.out_free;
            end
         end
         ple_pkg::S_INS_CHK:
            cmd.op = flags.ins_more ? ple_pkg::OP_INS_RD : ple_pkg::OP_INS_FIN;
         ple_pkg::S_INS_WR:   cmd.op = ple_pkg::OP_INS_WR;
         ple_pkg::S_DEL_SAVE: cmd.op = ple_pkg::OP_DEL_SAVE;
         ple_pkg::S_DEL_CHK:
            cmd.op = flags.del_more ? ple_pkg::OP_DEL_RD : ple_pkg::OP_DEL_FIN;
         ple_pkg::S_DEL_WR:   cmd.op = ple_pkg::OP_DEL_WR;
         ple_pkg::S_EMIT_IDX: begin
            cmd.emit = flags.out_free;
            cmd.vsel = ple_pkg::VS_A;
            cmd.psel = ple_pkg::PS_IDX;
         end
         ple_pkg::S_SORT_OUT: if (flags.i_lt) cmd.op = ple_pkg::OP_SORT_RA;
         ple_pkg::S_SORT_LA:  cmd.op = ple_pkg::OP_SORT_LA;
         ple_pkg::S_SORT_IN:
            cmd.op = flags.j_lt ? ple_pkg::OP_SORT_RB : ple_pkg::OP_SORT_WI;
         ple_pkg::S_SORT_CMP: cmd.op = ple_pkg::OP_SORT_CMP;
         ple_pkg::S_EMIT_OK:  cmd.emit = flags.out_free;
         ple_pkg::S_SRCH_RD:  if (flags.i_lt) cmd.op = ple_pkg::OP_SCAN_RD;
         ple_pkg::S_SRCH_CHK: begin
            if (!(flags.match && flags.pend && !flags.out_free)) begin
               cmd.op   = ple_pkg::OP_SRCH_CHK;
               cmd.emit = flags.match && flags.pend;
               cmd.vsel = ple_pkg::VS_REQ;
               cmd.psel = ple_pkg::PS_MPOS;
               cmd.last = 1'b0;
            end
         end
         ple_pkg::S_SRCH_END: begin
            cmd.emit = flags.out_free;
            cmd.vsel = ple_pkg::VS_REQ;
            if (flags.pend) begin
               cmd.psel = ple_pkg::PS_MPOS;
            end else begin
               cmd.st = ple_pkg::ST_NOTFOUND;
            end
         end
         ple_pkg::S_DISP_RD: cmd.op = ple_pkg::OP_SCAN_RD;
         ple_pkg::S_DISP_EMIT: begin
            if (flags.out_free) begin
               cmd.op   = ple_pkg::OP_DISP_NEXT;
               cmd.emit = 1'b1;
               cmd.vsel = ple_pkg::VS_RD;
               cmd.psel = ple_pkg::PS_I;
               cmd.last = flags.disp_last;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ple_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/positional_list_engine_top.sv]
// A status-only request gives its result word from the decode state; update writes the word, and
// insert and delete first shift the words behind the position before the result is given.
// Search and display read each element in turn; sort compares every pair of elements.
// One request in flight at a time; the next word is taken the cycle after the last result
// is registered. A stalled result holds the engine until the output is free.
// Synchronous reset empties the list (count zero); list RAM contents are not cleared.
module positional_list_engine_top #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_type,
   input  logic [4:0]         req_position,
   input  logic signed [31:0] req_element_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_out_value,
   output logic [4:0]         rsp_out_position,
   output logic [4:0]         rsp_element_count,
   output logic               rsp_last_result
);

   ple_pkg::cmd_type   cmd;
   ple_pkg::flags_type flags;

   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .flags     (flags),
      .cmd       (cmd)
   );

   ple_dp #(.CAPACITY(CAPACITY)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .flags             (flags),
      .req_type          (req_type),
      .req_position      (req_position),
      .req_element_value (req_element_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_out_value     (rsp_out_value),
      .rsp_out_position  (rsp_out_position),
      .rsp_element_count (rsp_element_count),
      .rsp_last_result   (rsp_last_result)
   );

endmodule
